// File: rtl/tib_pkg.sv
package tib_pkg;

    localparam int RANGE_SLOTS = 32;
    localparam int COST_LIMIT  = 64;
    localparam int MAX_CMDS    = 64;

    localparam int ADDR_W     = 64;
    localparam int PCID_W     = 12;
    localparam int SEL_W      = 2;
    localparam int CMD_KIND_W = 2;
    localparam int SHIFT_W    = 6;

    localparam int SLOT_IDX_W = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(RANGE_SLOTS + 1);
    localparam int COST_W     = $clog2(COST_LIMIT + 2);
    localparam int NCMD_W     = $clog2(MAX_CMDS + 1);

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 80;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_COMMIT = 1'b1;

    localparam logic [CMD_KIND_W-1:0] CMD_FLUSH_ALL     = 2'd0;
    localparam logic [CMD_KIND_W-1:0] CMD_FLUSH_PCID    = 2'd1;
    localparam logic [CMD_KIND_W-1:0] CMD_INV_PAGE      = 2'd2;
    localparam logic [CMD_KIND_W-1:0] CMD_INV_PAGE_PCID = 2'd3;

    localparam logic [SEL_W-1:0] SEL_4K = 2'd0;
    localparam logic [SEL_W-1:0] SEL_2M = 2'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] bytes;
        logic [SEL_W-1:0]  stride;
    } tib_slot_t;

    typedef struct packed {
        logic [CMD_KIND_W-1:0] kind;
        logic [PCID_W-1:0]     pcid;
        logic [ADDR_W-1:0]     vaddr;
    } tib_cmd_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic add_update;
        logic rd_slot;
        logic load_slot;
        logic gen_whole;
        logic gen_page;
        logic next_slot;
        logic finish;
    } tib_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic in_commit;
        logic in_pcid_zero;
        logic batch_flush;
        logic global_seen;
        logic count_zero;
        logic pages_done;
        logic cmd_cap;
        logic slot_more;
        logic pend_valid;
        logic out_free;
    } tib_stat_t;

    function automatic logic [SHIFT_W-1:0] page_shift(input logic [SEL_W-1:0] sel);
        logic [SHIFT_W-1:0] sh;
        if (sel == SEL_4K) begin
            sh = 6'd12;
        end else if (sel == SEL_2M) begin
            sh = 6'd21;
        end else begin
            sh = 6'd30;
        end
        return sh;
    endfunction

endpackage

// File: rtl/tib_ctrl.sv
module tib_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  tib_pkg::tib_stat_t st,
    output tib_pkg::tib_ctrl_t ctl
);
    import tib_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_LD   = 3'd3;
    localparam logic [2:0] S_PG   = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       has_work;

    assign s_tready = (state_reg == S_IDLE);
    assign has_work = st.global_seen || !st.in_pcid_zero;

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.load_in = 1'b1;
                    if (!st.in_commit) begin
                        state_next = S_ADD;
                    end else if (st.batch_flush) begin
                        ctl.gen_whole = has_work;
                        state_next    = S_FIN;
                    end else if (!st.count_zero && has_work) begin
                        state_next = S_RD;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_ADD: begin
                ctl.add_update = 1'b1;
                state_next     = S_IDLE;
            end
            S_RD: begin
                ctl.rd_slot = 1'b1;
                state_next  = S_LD;
            end
            S_LD: begin
                ctl.load_slot = 1'b1;
                state_next    = S_PG;
            end
            S_PG: begin
                if (st.pages_done || st.cmd_cap) begin
                    if (st.slot_more && !st.cmd_cap) begin
                        ctl.next_slot = 1'b1;
                        state_next    = S_RD;
                    end else begin
                        state_next = S_FIN;
                    end
                end else if (!st.pend_valid || st.out_free) begin
                    ctl.gen_page = 1'b1;
                end
            end
            S_FIN: begin
                if (!st.pend_valid || st.out_free) begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/tib_dp.sv
module tib_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [tib_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tib_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [tib_pkg::CMD_KIND_W-1:0]      m_tuser,
    output logic                                m_tlast,
    input  tib_pkg::tib_ctrl_t                  ctl,
    output tib_pkg::tib_stat_t                  st
);
    import tib_pkg::*;

    // unpack input item
    logic [ADDR_W-1:0] s_vaddr;
    logic [ADDR_W-1:0] s_bytes;
    logic [SEL_W-1:0]  s_sel;
    logic              s_glob;
    logic [PCID_W-1:0] s_pcid;

    assign s_vaddr = s_tdata[63:0];
    assign s_bytes = s_tdata[127:64];
    assign s_sel   = s_tdata[129:128];
    assign s_glob  = s_tdata[130];
    assign s_pcid  = s_tdata[142:131];

    // slot memory
    tib_slot_t mem [RANGE_SLOTS];
    tib_slot_t rd_reg;
    logic [SLOT_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] wr_addr;
    tib_slot_t             wr_data;

    // latched item
    logic [ADDR_W-1:0] in_va_reg;
    logic [ADDR_W-1:0] in_bytes_reg;
    logic [SEL_W-1:0]  in_sel_reg;
    logic              in_glob_reg;
    logic [PCID_W-1:0] in_pcid_reg;
    logic [COST_W-1:0] in_cost_reg;
    logic              in_over_reg;

    // batch state
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [COST_W-1:0] cost_reg,   cost_next;
    logic              flush_reg,  flush_next;
    logic              global_reg, global_next;

    // emission
    logic [SLOT_IDX_W-1:0] slot_i_reg;
    logic [NCMD_W-1:0]     ncmd_reg;
    logic [NCMD_W-1:0]     pages_reg;
    logic [ADDR_W-1:0]     cur_va_reg;
    logic [ADDR_W-1:0]     step_reg;
    tib_cmd_t              pend_reg;
    logic                  pend_valid_reg;
    tib_cmd_t              out_reg;
    logic                  out_valid_reg;
    logic                  out_last_reg;

    logic [SLOT_IDX_W-1:0] tail_idx;
    logic [ADDR_W-1:0]     shifted;
    logic [ADDR_W-1:0]     slot_pages;
    logic [SHIFT_W-1:0]    slot_sh;
    logic [COST_W:0]       cost_sum;
    logic                  merge;
    logic                  plain;
    logic                  out_free;
    logic                  push_out;

    assign tail_idx = count_reg[SLOT_IDX_W-1:0] - 1'b1;
    assign rd_addr  = ctl.load_in ? tail_idx : slot_i_reg;
    assign shifted  = s_bytes >> page_shift(s_sel);
    assign slot_sh  = page_shift(rd_reg.stride);
    assign slot_pages = rd_reg.bytes >> slot_sh;
    assign cost_sum = {1'b0, cost_reg} + {1'b0, in_cost_reg};
    assign merge    = (count_reg != '0) && (rd_reg.start + rd_reg.bytes == in_va_reg) &&
                      (rd_reg.stride == in_sel_reg);
    assign plain    = global_reg || (in_pcid_reg == '0);
    assign out_free = !out_valid_reg || m_tready;
    assign push_out = (ctl.gen_page || ctl.finish) && pend_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load_in || ctl.rd_slot) begin
            rd_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // finish clears the batch; add: cost check, then extend last range, take a new slot or go to flush
    always_comb begin
        count_next  = count_reg;
        cost_next   = cost_reg;
        flush_next  = flush_reg;
        global_next = global_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[SLOT_IDX_W-1:0];
        wr_data     = '{start: in_va_reg, bytes: in_bytes_reg, stride: in_sel_reg};
        if (ctl.finish) begin
            count_next  = '0;
            cost_next   = '0;
            flush_next  = 1'b0;
            global_next = 1'b0;
        end else if (ctl.add_update && !flush_reg) begin
            global_next = global_reg | in_glob_reg;
            if (in_over_reg || cost_sum > (COST_W+1)'(COST_LIMIT)) begin
                cost_next  = COST_W'(COST_LIMIT + 1);
                flush_next = 1'b1;
            end else begin
                cost_next = cost_sum[COST_W-1:0];
                if (merge) begin
                    wr_en   = 1'b1;
                    wr_addr = tail_idx;
                    wr_data = '{start: rd_reg.start, bytes: rd_reg.bytes + in_bytes_reg,
                                stride: rd_reg.stride};
                end else if (count_reg < CNT_W'(RANGE_SLOTS)) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end else begin
                    flush_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            in_va_reg    <= s_vaddr;
            in_bytes_reg <= s_bytes;
            in_sel_reg   <= s_sel;
            in_glob_reg  <= s_glob;
            in_pcid_reg  <= s_pcid;
            in_over_reg  <= shifted > ADDR_W'(COST_LIMIT);
            in_cost_reg  <= (shifted == '0) ? COST_W'(1) : shifted[COST_W-1:0];
        end
        if (ctl.load_slot) begin
            cur_va_reg <= rd_reg.start;
            step_reg   <= ADDR_W'(1) << slot_sh;
        end else if (ctl.gen_page) begin
            cur_va_reg <= cur_va_reg + step_reg;
        end
        if (ctl.gen_whole) begin
            pend_reg.kind  <= global_reg ? CMD_FLUSH_ALL : CMD_FLUSH_PCID;
            pend_reg.pcid  <= global_reg ? '0 : s_pcid;
            pend_reg.vaddr <= '0;
        end else if (ctl.gen_page) begin
            pend_reg.kind  <= plain ? CMD_INV_PAGE : CMD_INV_PAGE_PCID;
            pend_reg.pcid  <= plain ? '0 : in_pcid_reg;
            pend_reg.vaddr <= cur_va_reg;
        end
        if (push_out) begin
            out_reg      <= pend_reg;
            out_last_reg <= ctl.finish;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            cost_reg       <= '0;
            flush_reg      <= 1'b0;
            global_reg     <= 1'b0;
            slot_i_reg     <= '0;
            ncmd_reg       <= '0;
            pages_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            count_reg  <= count_next;
            cost_reg   <= cost_next;
            flush_reg  <= flush_next;
            global_reg <= global_next;
            if (ctl.finish) begin
                slot_i_reg <= '0;
                ncmd_reg   <= '0;
            end else if (ctl.next_slot) begin
                slot_i_reg <= slot_i_reg + 1'b1;
            end else if (ctl.gen_page) begin
                ncmd_reg <= ncmd_reg + 1'b1;
            end
            if (ctl.load_slot) begin
                // cap page count; emission never goes past the command limit
                pages_reg <= (slot_pages > ADDR_W'(MAX_CMDS)) ? NCMD_W'(MAX_CMDS)
                                                               : slot_pages[NCMD_W-1:0];
            end else if (ctl.gen_page) begin
                pages_reg <= pages_reg - 1'b1;
            end
            if (ctl.gen_whole || ctl.gen_page) begin
                pend_valid_reg <= 1'b1;
            end else if (ctl.finish) begin
                pend_valid_reg <= 1'b0;
            end
            if (push_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.vaddr, out_reg.pcid};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;

    assign st.in_commit    = (s_tuser == FUNC_COMMIT);
    assign st.in_pcid_zero = (s_pcid == '0);
    assign st.batch_flush  = flush_reg;
    assign st.global_seen  = global_reg;
    assign st.count_zero   = (count_reg == '0);
    assign st.pages_done   = (pages_reg == '0);
    assign st.cmd_cap      = (ncmd_reg == NCMD_W'(MAX_CMDS));
    assign st.slot_more    = (CNT_W'(slot_i_reg) + 1'b1) < count_reg;
    assign st.pend_valid   = pend_valid_reg;
    assign st.out_free     = out_free;

endmodule

// File: rtl/tlb_invalidation_batcher_top.sv
// TLB invalidation batcher.
// Input channel (s_): one item per add or commit. s_tuser selects the kind
// (0 add a range, 1 commit). Adds carry address, byte size, page size and a
// global mark; a commit carries the PCID of the address space.
// Result channel (m_): one flush command per transfer, m_tuser is the command kind,
// m_tlast marks the last command of a commit.
// Sequence: an add is accepted, reading the last stored slot, then merges into
// that slot, writes a new one in the range memory or enters flush mode. A
// commit is accepted, then for each stored range reads the slot, loads it and
// checks for the end of the range while it emits page commands; at most 64
// commands leave per commit. One command is held back in a pending register so
// the last mark is known before it goes out. A commit in flush mode emits a
// whole flush, if any, instead. Reset clears the batch (count, cost, flush-all
// and global marks) and drops any output in flight; the range memory is not
// cleared, only entries below the stored count are ever used.
// A stall on m_tready holds the output register and freezes command
// generation; no new item is taken until the commit has emitted all commands.
module tlb_invalidation_batcher_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // [63:0] vaddr, [127:64] range_bytes, [129:128] page_size_sel,
    // [130] is_global_page, [142:131] pcid, [143] zero
    input  logic [143:0]  s_tdata,
    // [0] func
    input  logic          s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // [11:0] out_pcid, [75:12] out_vaddr, [79:76] zero
    output logic [79:0]   m_tdata,
    // [1:0] cmd
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);
    import tib_pkg::*;

    tib_ctrl_t ctl;
    tib_stat_t st;

    tib_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .ctl      (ctl)
    );

    tib_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .ctl      (ctl),
        .st       (st)
    );

    // the pending command is always flushed before a new item is taken
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !st.pend_valid)
        else $error("pending command left over while idle");

    // never generate past the per-commit command limit
    a_cmd_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.gen_page |-> !st.cmd_cap)
        else $error("page command generated beyond limit");

    // every accepted item takes the block out of idle, so no item is accepted back to back
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted back to back");

    // a command only moves to the output register when the register is free
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ((ctl.gen_page || ctl.finish) && st.pend_valid) |-> st.out_free)
        else $error("output register overwritten");

endmodule

// File: tb/tib_flush_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the invalidation batcher, predicts the flush
// commands of each commit and compares them in order with what leaves.
module tib_flush_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tib_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [tib_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [1:0]                     m_tuser,
    input  logic                           m_tlast,
    output int                             mismatch_count,
    output int                             pending_cmds
);
    import tib_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CMD_KIND_W-1:0] kind;
        logic [PCID_W-1:0]     pcid;
        logic [ADDR_W-1:0]     vaddr;
        logic                  last;
    } flush_cmd_t;

    // predicted batch contents
    logic [ADDR_W-1:0] range_base [RANGE_SLOTS];
    logic [ADDR_W-1:0] range_len  [RANGE_SLOTS];
    logic [SEL_W-1:0]  range_sel  [RANGE_SLOTS];
    int unsigned       ranges_used;
    int unsigned       batch_cost;
    logic              flush_mode;
    logic              saw_global;

    flush_cmd_t cmd_expect_q[$];

    function automatic int unsigned shift_of(input logic [SEL_W-1:0] sel);
        case (sel)
            SEL_4K: return 12;
            SEL_2M: return 21;
            default: return 30;
        endcase
    endfunction

    function automatic void reset_batch();
        ranges_used = 0;
        batch_cost  = 0;
        flush_mode  = 1'b0;
        saw_global  = 1'b0;
    endfunction

    function automatic void absorb_range(input logic [ADDR_W-1:0] va,
                                         input logic [ADDR_W-1:0] nbytes,
                                         input logic [SEL_W-1:0] sel,
                                         input logic glob);
        logic [ADDR_W-1:0] cost;
        int unsigned tail;
        if (flush_mode) return;
        cost = nbytes >> shift_of(sel);
        if (cost == 0) cost = 64'd1;
        if (glob) saw_global = 1'b1;
        if (cost > COST_LIMIT || batch_cost + cost > COST_LIMIT) begin
            // saturate just above the limit
            batch_cost = COST_LIMIT + 1;
            flush_mode = 1'b1;
            return;
        end
        batch_cost += 32'(cost);
        if (ranges_used > 0) begin
            tail = ranges_used - 1;
            if (range_base[tail] + range_len[tail] == va && range_sel[tail] == sel) begin
                range_len[tail] += nbytes;
                return;
            end
        end
        if (ranges_used < RANGE_SLOTS) begin
            range_base[ranges_used] = va;
            range_len[ranges_used]  = nbytes;
            range_sel[ranges_used]  = sel;
            ranges_used++;
        end else begin
            flush_mode = 1'b1;
        end
    endfunction

    function automatic void drain_batch(input logic [PCID_W-1:0] pc);
        flush_cmd_t burst[$];
        flush_cmd_t c;
        logic plain;
        int unsigned sh;
        int unsigned i;
        logic [ADDR_W-1:0] pages;
        logic [ADDR_W-1:0] j;
        c = '0;
        if (flush_mode) begin
            if (saw_global) begin
                c.kind = CMD_FLUSH_ALL;
                burst.push_back(c);
            end else if (pc != 0) begin
                c.kind = CMD_FLUSH_PCID;
                c.pcid = pc;
                burst.push_back(c);
            end
        end else if (ranges_used > 0 && (saw_global || pc != 0)) begin
            plain = saw_global || pc == 0;
            for (i = 0; i < ranges_used && burst.size() < MAX_CMDS; i++) begin
                sh    = shift_of(range_sel[i]);
                pages = range_len[i] >> sh;
                for (j = '0; j < pages && burst.size() < MAX_CMDS; j++) begin
                    c.kind  = plain ? CMD_INV_PAGE : CMD_INV_PAGE_PCID;
                    c.pcid  = plain ? '0 : pc;
                    c.vaddr = range_base[i] + (j << sh);
                    burst.push_back(c);
                end
            end
        end
        if (burst.size() > 0) begin
            c = burst.pop_back();
            c.last = 1'b1;
            burst.push_back(c);
        end
        foreach (burst[k]) cmd_expect_q.push_back(burst[k]);
        reset_batch();
    endfunction

    task automatic check_command();
        flush_cmd_t want;
        flush_cmd_t seen;
        seen.kind  = m_tuser;
        seen.pcid  = m_tdata[11:0];
        seen.vaddr = m_tdata[75:12];
        seen.last  = m_tlast;
        if (cmd_expect_q.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
                $display("%0t: unexpected command kind %0d pcid %h vaddr %h last %b",
                         $time, seen.kind, seen.pcid, seen.vaddr, seen.last);
            mismatch_count++;
        end else begin
            want = cmd_expect_q.pop_front();
            if (want !== seen) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display({"%0t: command mismatch: expected kind %0d pcid %h vaddr %h ",
                              "last %b, got kind %0d pcid %h vaddr %h last %b"},
                             $time, want.kind, want.pcid, want.vaddr, want.last,
                             seen.kind, seen.pcid, seen.vaddr, seen.last);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_batch();
            cmd_expect_q.delete();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) check_command();
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_COMMIT) drain_batch(s_tdata[142:131]);
                else absorb_range(s_tdata[63:0], s_tdata[127:64], s_tdata[129:128],
                                  s_tdata[130]);
            end
        end
        pending_cmds = cmd_expect_q.size();
    end

endmodule

// File: tb/tb_tlb_invalidation_batcher_top.sv
`timescale 1ns / 1ps

module tb_tlb_invalidation_batcher_top;
    import tib_pkg::*;

    // 1G granularity and the spare selector code that the block treats as 1G
    localparam logic [SEL_W-1:0] SEL_1G    = 2'd2;
    localparam logic [SEL_W-1:0] SEL_SPARE = 2'd3;

    localparam int RANDOM_ITEMS   = 100;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES    = 200;
    localparam int LIMIT_CYCLES   = 1500000;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata  = '0;   // [63:0] vaddr, [127:64] range_bytes,
                                   // [129:128] page_size_sel, [130] is_global_page,
                                   // [142:131] pcid, [143] zero
    logic         s_tuser  = 1'b0; // [0] func
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;         // [11:0] out_pcid, [75:12] out_vaddr, [79:76] zero
    logic [1:0]   m_tuser;         // [1:0] cmd
    logic         m_tlast;

    int mismatch_count;
    int pending_cmds;
    int cycle_count = 0;
    int sent_items  = 0;

    // idle bookkeeping for both channel sides
    int unsigned tx_calm      = 0;
    int unsigned rx_gap       = 0;
    int unsigned rx_calm      = 0;
    bit          rx_hold_req  = 1'b0;
    bit          rx_hold_done = 1'b0;

    always #2 aclk = ~aclk;

    tlb_invalidation_batcher_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tib_flush_checker u_flush_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_cmds   (pending_cmds)
    );

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tlb_invalidation_batcher_top verification failed");
            $finish;
        end
    end

    // Mostly back-to-back, some short gaps, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Commit PCID: zero and all-ones show up often, the rest is random.
    function automatic logic [11:0] pick_pcid();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 12'h000;
        if (roll == 1) return 12'hFFF;
        return 12'($urandom_range(1, 4095));
    endfunction

    // Offer one item, hold it until accepted, then maybe idle the input side.
    task automatic send_item(input logic func, input logic [63:0] va,
                             input logic [63:0] nbytes, input logic [1:0] sel,
                             input logic glob, input logic [11:0] pc);
        int unsigned idle;
        s_tuser  <= func;
        s_tdata  <= {1'b0, pc, glob, sel, nbytes, va};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent_items++;
        if (tx_calm > 0) begin
            tx_calm--;
            idle = 0;
        end else if ($urandom_range(0, 24) == 0) begin
            tx_calm = $urandom_range(20, 60);
            idle = 0;
        end else begin
            idle = idle_len();
        end
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
    endtask

    // Fields that an add ignores (pcid) get random content.
    task automatic add_range(input logic [63:0] va, input logic [63:0] nbytes,
                             input logic [1:0] sel, input logic glob);
        send_item(FUNC_ADD, va, nbytes, sel, glob, 12'($urandom_range(0, 4095)));
    endtask

    // Fields that a commit ignores get random content.
    task automatic commit_batch(input logic [11:0] pc);
        send_item(FUNC_COMMIT, rand64(), rand64(), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), pc);
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off on request.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (rx_hold_req && !rx_hold_done) begin
                // starve the result channel so the block backs up into its input
                m_tready     <= 1'b0;
                rx_hold_done  = 1'b1;
                rx_gap        = RX_HOLD_CYCLES;
            end else if (rx_gap > 0) begin
                m_tready <= 1'b0;
                rx_gap--;
            end else begin
                m_tready <= 1'b1;
                if (rx_calm > 0) rx_calm--;
                else if ($urandom_range(0, 19) == 0) rx_calm = $urandom_range(30, 90);
                else rx_gap = idle_len();
            end
        end
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned k;
        int unsigned sh;
        int unsigned roll;
        int          rand_start;
        bit          slot_fill_done;
        logic [63:0] va;
        logic [63:0] nbytes;
        logic [63:0] pg;
        logic [1:0]  sel;

        slot_fill_done = 1'b0;
        nbytes = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Commit with nothing stored: no commands, state cleared anyway.
        commit_batch(12'h005);

        // Contiguous 4K merge plus a zero-byte 2M slot, PCID-tagged pages.
        add_range(64'h1000, 64'h3000, SEL_4K, 1'b0);
        add_range(64'h4000, 64'h2000, SEL_4K, 1'b0);
        add_range(64'h20_0000, 64'h0, SEL_2M, 1'b0);
        commit_batch(12'hFFF);

        // Global range that wraps past the top of the address space and merges.
        add_range(64'hFFFF_FFFF_FFFF_E000, 64'h3000, SEL_4K, 1'b1);
        add_range(64'h1000, 64'h1000, SEL_4K, 1'b0);
        commit_batch(12'h000);

        // 2M and 1G strides; the spare selector acts as 1G but never merges with 1G.
        add_range(64'h60_0000, 64'h40_0000, SEL_2M, 1'b0);
        add_range(64'h4000_0000, 64'h8000_0000, SEL_1G, 1'b0);
        add_range(64'hC000_0000, 64'h4000_0000, SEL_SPARE, 1'b0);
        commit_batch(12'h001);

        // Non-global batch committed with PCID zero emits nothing.
        add_range(64'hFFFF_FFFF_FFFF_FFFF, 64'h1000, SEL_4K, 1'b0);
        commit_batch(12'h000);

        // Huge range forces flush-all; a later global add is dropped -> PCID flush.
        add_range(rand64(), 64'hFFFF_FFFF_FFFF_FFFF, SEL_SPARE, 1'b0);
        add_range(rand64(), 64'h1000, SEL_4K, 1'b1);
        commit_batch(12'hABC);

        // Cost adds up past the limit with a global page -> flush everything.
        add_range(rand64(), 64'h28000, SEL_4K, 1'b1);
        add_range(rand64(), 64'h19000, SEL_4K, 1'b0);
        commit_batch(12'h000);

        // Odd-sized contiguous adds merge into more pages than they cost;
        // emission is capped and the cap carries the last mark.
        va = 64'h10_0000_0000;
        for (k = 0; k < 9; k++) begin
            add_range(va, 64'h7FFF, SEL_4K, 1'b0);
            va = va + 64'h7FFF;
        end
        commit_batch(12'h456);

        // Random phase opens with a full 64-page commit while the sink holds off.
        rand_start  = sent_items;
        rx_hold_req = 1'b1;
        add_range(rand64() & ~64'hFFF, 64'h40000, SEL_4K, 1'b0);
        commit_batch(12'h7A5);

        while (sent_items - rand_start < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (!slot_fill_done && (roll < 5 || sent_items - rand_start > RANDOM_ITEMS / 2))
            begin
                // Run the slots out: one past the slot count tips into flush-all.
                slot_fill_done = 1'b1;
                n  = $urandom_range(RANGE_SLOTS, RANGE_SLOTS + 2);
                va = rand64() & ~64'hF_FFFF;
                for (k = 0; k < n; k++) begin
                    add_range(va, $urandom_range(0, 1) ? 64'h1000 : 64'h0, SEL_4K,
                              $urandom_range(0, 9) == 0);
                    va = va + 64'h2_0000;
                end
                commit_batch(pick_pcid());
            end else if (roll < 60) begin
                // Well-formed batch: a few ranges, often contiguous, then commit.
                n = $urandom_range(1, 6);
                sel = SEL_4K;
                va  = '0;
                for (k = 0; k < n; k++) begin
                    if (k == 0 || $urandom_range(0, 1) == 0) begin
                        sel = 2'($urandom_range(0, 3));
                        va  = rand64();
                        if ($urandom_range(0, 3) != 0) va = va & ~64'hFFF;
                    end else begin
                        va = va + nbytes;
                        if ($urandom_range(0, 3) == 0) sel = 2'($urandom_range(0, 3));
                    end
                    sh = (sel == SEL_4K) ? 12 : (sel == SEL_2M) ? 21 : 30;
                    pg = 64'($urandom_range(0, 6));
                    nbytes = pg << sh;
                    if ($urandom_range(0, 2) == 0)
                        nbytes = nbytes | 64'($urandom_range(0, 4095));
                    add_range(va, nbytes, sel, $urandom_range(0, 4) == 0);
                end
                commit_batch(pick_pcid());
            end else if (roll < 75) begin
                // Overflow batch: large adds, often pushing the cost over the limit.
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++) begin
                    pg = 64'($urandom_range(20, 64));
                    add_range(rand64(), pg << 12, SEL_4K, $urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 1) == 0)
                    add_range(rand64(), rand64(), 2'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)));
                commit_batch(pick_pcid());
            end else begin
                // Noise: every field fully random.
                send_item(1'($urandom_range(0, 1)), rand64(), rand64(),
                          2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          12'($urandom_range(0, 4095)));
            end
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every predicted command, then let stragglers show up.
        @(negedge aclk);
        while (pending_cmds != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_cmds == 0) begin
            $display("tlb_invalidation_batcher_top verification clean");
        end else begin
            $display("tlb_invalidation_batcher_top verification failed");
        end
        $finish;
    end

endmodule
